@@ rtl/fpa_pkg.sv @@
// ----------------------------------------------------------------------------
// fpa_pkg: shared types and codes for the first-fit pool allocator
// Field widths, command and status codes, datapath command and status bundles.
// ----------------------------------------------------------------------------
package fpa_pkg;

	// item field widths
	localparam int CMD_W    = 1;
	localparam int SIZE_W   = 10;
	localparam int OFF_W    = 10;
	localparam int STATUS_W = 2;

	// command codes
	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOFIT  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BADOFF = 2'd2;

	// datapath micro-operations issued by the controller
	typedef enum logic [3:0] {
		OP_NONE,
		OP_INIT,
		OP_LOAD,
		OP_SCAN,
		OP_FIT,
		OP_DN0,
		OP_DN,
		OP_SPLIT_HI,
		OP_SPLIT_LO,
		OP_NEXT,
		OP_MERGE,
		OP_UP,
		OP_SHRINK,
		OP_RES
	} dp_op_t;

	typedef struct packed {
		dp_op_t              op;
		logic [STATUS_W-1:0] status;
		logic                grant;
	} dp_cmd_t;

	typedef struct packed {
		logic is_free;
		logic hit;
		logic last;
		logic exact;
		logic split_ok;
		logic hfree;
		logic dn_any;
		logic dn_more;
		logic up_any;
		logic up_more;
		logic out_busy;
	} dp_stat_t;

endpackage

@@ rtl/fpa_req_if.sv @@
// ----------------------------------------------------------------------------
// fpa_req_if: request channel
// valid/ready channel carrying one allocate or free item.
// ----------------------------------------------------------------------------
interface fpa_req_if import fpa_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  command;
	logic [SIZE_W-1:0] request_size;
	logic [OFF_W-1:0]  payload_offset;

	modport source (
		output valid, command, request_size, payload_offset,
		input  ready
	);
	modport sink (
		input  valid, command, request_size, payload_offset,
		output ready
	);
endinterface

@@ rtl/fpa_rsp_if.sv @@
// ----------------------------------------------------------------------------
// fpa_rsp_if: result channel
// valid/ready channel carrying one status item per request.
// ----------------------------------------------------------------------------
interface fpa_rsp_if import fpa_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [OFF_W-1:0]    granted_offset;

	modport source (
		output valid, status, granted_offset,
		input  ready
	);
	modport sink (
		input  valid, status, granted_offset,
		output ready
	);
endinterface

@@ rtl/fpa_dp.sv @@
// ----------------------------------------------------------------------------
// fpa_dp: allocator datapath
// Block table memory, scan pointer and address accumulator, entry shift
// engine, merge adder and the result register.
// ----------------------------------------------------------------------------
module fpa_dp import fpa_pkg::*; #(
	parameter int POOL_BYTES   = 1024,
	parameter int HEADER_BYTES = 24,
	parameter int MAX_BLOCKS   = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  dp_cmd_t             cmd,
	output dp_stat_t            stat,
	input  logic [CMD_W-1:0]    command,
	input  logic [SIZE_W-1:0]   request_size,
	input  logic [OFF_W-1:0]    payload_offset,
	output logic                res_valid,
	input  logic                res_ready,
	output logic [STATUS_W-1:0] status,
	output logic [OFF_W-1:0]    granted_offset
);

	localparam int SW = $clog2(POOL_BYTES + 1);
	localparam int IW = $clog2(MAX_BLOCKS);
	localparam int CW = $clog2(MAX_BLOCKS + 1);
	localparam int EW = ((SW > SIZE_W) ? SW : SIZE_W) + 1;
	localparam int DW = SW + 1;
	localparam logic [EW-1:0] HDR_E     = EW'(HEADER_BYTES);
	localparam logic [SW-1:0] INIT_SIZE = SW'(POOL_BYTES - HEADER_BYTES);
	localparam logic [CW-1:0] MAXC      = CW'(MAX_BLOCKS);

	// block table: {free, size}
	logic [DW-1:0] mem [MAX_BLOCKS];
	logic [DW-1:0] rd_q;

	logic [CMD_W-1:0]  cmd_q;
	logic [SIZE_W-1:0] req_q;
	logic [OFF_W-1:0]  off_q;
	logic [CW-1:0]     cnt_q;
	logic [IW-1:0]     eidx_q, hidx_q, src_q;
	logic [SW-1:0]     addr_q, hsz_q, ps_q, ns_q;
	logic              hfree_q, pf_q, nf_q;
	logic              out_valid_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [OFF_W-1:0]  out_grant_q;

	logic              ent_free;
	logic [SW-1:0]     ent_size;
	logic [EW-1:0]     ent_e, req_e, off_e, addr_e, hsz_e, ns_e, ps_e;
	logic [EW-1:0]     gr_e, next_addr_e, rem_e, tsize_e;
	logic [CW-1:0]     eidx_n, hidx_n, src_n, cnt_m1, up_dst_w;
	logic [CW:0]       s0;
	logic [1:0]        r;
	logic [IW-1:0]     src_p1, src_m1, hidx_p1, tidx, up_dst;
	logic              alloc_hit, free_hit, hit, last;
	logic              dn_more, up_any, up_more;

	logic              wr_en, rd_en;
	logic [IW-1:0]     wr_addr, rd_addr;
	logic [DW-1:0]     wr_data;

	// operand extension
	assign ent_free = rd_q[SW];
	assign ent_size = rd_q[SW-1:0];
	assign ent_e    = EW'(ent_size);
	assign req_e    = EW'(req_q);
	assign off_e    = EW'(off_q);
	assign addr_e   = EW'(addr_q);
	assign hsz_e    = EW'(hsz_q);
	assign ns_e     = EW'(ns_q);
	assign ps_e     = EW'(ps_q);

	// scan compare and address step
	assign gr_e        = addr_e + HDR_E;
	assign next_addr_e = gr_e + ent_e;
	assign alloc_hit   = ent_free && (ent_e >= req_e);
	assign free_hit    = (gr_e == off_e);
	assign hit         = (cmd_q == CMD_FREE) ? free_hit : alloc_hit;
	assign eidx_n      = CW'(eidx_q) + 1'b1;
	assign last        = (eidx_n >= cnt_q);

	// index arithmetic
	assign hidx_n   = CW'(hidx_q) + 1'b1;
	assign hidx_p1  = hidx_q + 1'b1;
	assign src_n    = CW'(src_q) + 1'b1;
	assign src_p1   = src_q + 1'b1;
	assign src_m1   = src_q - 1'b1;
	assign cnt_m1   = cnt_q - 1'b1;
	assign r        = {1'b0, nf_q} + {1'b0, pf_q};
	assign s0       = (CW+1)'(hidx_n) + (CW+1)'(nf_q);
	assign tidx     = pf_q ? (hidx_q - 1'b1) : hidx_q;
	assign up_dst_w = CW'(src_q) - CW'(r);
	assign up_dst   = up_dst_w[IW-1:0];
	assign dn_more  = (CW'(src_q) > hidx_n);
	assign up_any   = (r != 2'd0) && (s0 < (CW+1)'(cnt_q));
	assign up_more  = (src_n < cnt_q);

	// split remainder and merged size
	assign rem_e   = hsz_e - req_e - HDR_E;
	assign tsize_e = hsz_e + (nf_q ? (HDR_E + ns_e) : '0) + (pf_q ? (HDR_E + ps_e) : '0);

	// status to controller
	always_comb begin
		stat.is_free  = (cmd_q == CMD_FREE);
		stat.hit      = hit;
		stat.last     = last;
		stat.exact    = (hsz_e == req_e);
		stat.split_ok = (hsz_e > (req_e + HDR_E)) && (cnt_q < MAXC);
		stat.hfree    = hfree_q;
		stat.dn_any   = (hidx_n < cnt_q);
		stat.dn_more  = dn_more;
		stat.up_any   = up_any;
		stat.up_more  = up_more;
		stat.out_busy = out_valid_q && !res_ready;
	end

	// memory port selection
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = '0;
		rd_en   = 1'b0;
		rd_addr = '0;
		unique case (cmd.op)
			OP_INIT: begin
				wr_en   = 1'b1;
				wr_data = {1'b1, INIT_SIZE};
			end
			OP_LOAD: begin
				rd_en = 1'b1;
			end
			OP_SCAN: begin
				rd_en   = 1'b1;
				rd_addr = eidx_n[IW-1:0];
			end
			OP_FIT: begin
				wr_en   = 1'b1;
				wr_addr = hidx_q;
				wr_data = {1'b0, hsz_q};
			end
			OP_DN0: begin
				rd_en   = 1'b1;
				rd_addr = cnt_m1[IW-1:0];
			end
			OP_DN: begin
				wr_en   = 1'b1;
				wr_addr = src_p1;
				wr_data = rd_q;
				rd_en   = dn_more;
				rd_addr = src_m1;
			end
			OP_SPLIT_HI: begin
				wr_en   = 1'b1;
				wr_addr = hidx_p1;
				wr_data = {1'b1, rem_e[SW-1:0]};
			end
			OP_SPLIT_LO: begin
				wr_en   = 1'b1;
				wr_addr = hidx_q;
				wr_data = {1'b0, SW'(req_q)};
			end
			OP_MERGE: begin
				wr_en   = 1'b1;
				wr_addr = tidx;
				wr_data = {1'b1, tsize_e[SW-1:0]};
				rd_en   = up_any;
				rd_addr = s0[IW-1:0];
			end
			OP_UP: begin
				wr_en   = 1'b1;
				wr_addr = up_dst;
				wr_data = rd_q;
				rd_en   = up_more;
				rd_addr = src_p1;
			end
			default: begin
			end
		endcase
	end

	// block table, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				cmd_q  <= command;
				req_q  <= request_size;
				off_q  <= payload_offset;
				eidx_q <= '0;
				addr_q <= '0;
				pf_q   <= 1'b0;
				ps_q   <= '0;
			end
			OP_SCAN: begin
				if (hit) begin
					hidx_q  <= eidx_q;
					hsz_q   <= ent_size;
					hfree_q <= ent_free;
				end else if (!last) begin
					eidx_q <= eidx_n[IW-1:0];
					addr_q <= next_addr_e[SW-1:0];
					pf_q   <= ent_free;
					ps_q   <= ent_size;
				end
			end
			OP_DN0: begin
				src_q <= cnt_m1[IW-1:0];
			end
			OP_DN: begin
				if (dn_more) begin
					src_q <= src_m1;
				end
			end
			OP_NEXT: begin
				nf_q <= (hidx_n < cnt_q) && ent_free;
				ns_q <= ent_size;
			end
			OP_MERGE: begin
				if (up_any) begin
					src_q <= s0[IW-1:0];
				end
			end
			OP_UP: begin
				if (up_more) begin
					src_q <= src_p1;
				end
			end
			OP_RES: begin
				out_status_q <= cmd.status;
				out_grant_q  <= cmd.grant ? gr_e[OFF_W-1:0] : '0;
			end
			default: begin
			end
		endcase
	end

	// block count and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= CW'(1);
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.op == OP_SPLIT_LO) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (cmd.op == OP_SHRINK) begin
				cnt_q <= cnt_q - CW'(r);
			end
			if (cmd.op == OP_RES) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign res_valid      = out_valid_q;
	assign status         = out_status_q;
	assign granted_offset = out_grant_q;

	// table always holds between one and MAX_BLOCKS entries
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != '0) && (cnt_q <= MAXC))
		else $error("block count out of range");

	// a split only commits when there is room for the new entry
	a_split_room: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_SPLIT_LO) |-> (cnt_q < MAXC))
		else $error("split with full table");

	// compaction never moves an entry onto or below the merge target
	a_up_dest: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_UP) |-> ((CW'(src_q) >= CW'(r)) && (up_dst > tidx)))
		else $error("compaction destination below merge target");

	// merging into a previous block needs a previous block
	a_merge_prev: assert property (@(posedge clk) disable iff (!arst_n)
		((cmd.op == OP_MERGE) && pf_q) |-> (hidx_q != '0))
		else $error("merge into missing previous block");

endmodule

@@ rtl/fpa_ctrl.sv @@
// ----------------------------------------------------------------------------
// fpa_ctrl: allocator controller
// Sequences scan, split, merge and compaction steps and the result hand-off.
// ----------------------------------------------------------------------------
module fpa_ctrl import fpa_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	localparam logic [3:0] S_INIT   = 4'd0;
	localparam logic [3:0] S_IDLE   = 4'd1;
	localparam logic [3:0] S_SCAN   = 4'd2;
	localparam logic [3:0] S_DECIDE = 4'd3;
	localparam logic [3:0] S_DN     = 4'd4;
	localparam logic [3:0] S_SPL_HI = 4'd5;
	localparam logic [3:0] S_SPL_LO = 4'd6;
	localparam logic [3:0] S_MERGE  = 4'd7;
	localparam logic [3:0] S_UP     = 4'd8;
	localparam logic [3:0] S_FIN    = 4'd9;
	localparam logic [3:0] S_RES    = 4'd10;

	logic [3:0]          state_q, state_d;
	logic [STATUS_W-1:0] res_status_q, res_status_d;
	logic                res_grant_q, res_grant_d;
	dp_op_t              op;

	// next state and micro-op
	always_comb begin
		state_d      = state_q;
		res_status_d = res_status_q;
		res_grant_d  = res_grant_q;
		op           = OP_NONE;
		req_ready    = 1'b0;
		unique case (state_q)
			S_INIT: begin
				op      = OP_INIT;
				state_d = S_IDLE;
			end
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					op      = OP_LOAD;
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				op = OP_SCAN;
				if (stat.hit) begin
					state_d = S_DECIDE;
				end else if (stat.last) begin
					res_status_d = stat.is_free ? ST_BADOFF : ST_NOFIT;
					res_grant_d  = 1'b0;
					state_d      = S_RES;
				end
			end
			S_DECIDE: begin
				if (stat.is_free) begin
					if (stat.hfree) begin
						res_status_d = ST_BADOFF;
						res_grant_d  = 1'b0;
						state_d      = S_RES;
					end else begin
						op      = OP_NEXT;
						state_d = S_MERGE;
					end
				end else if (stat.exact) begin
					op           = OP_FIT;
					res_status_d = ST_OK;
					res_grant_d  = 1'b1;
					state_d      = S_RES;
				end else if (stat.split_ok) begin
					if (stat.dn_any) begin
						op      = OP_DN0;
						state_d = S_DN;
					end else begin
						op      = OP_SPLIT_HI;
						state_d = S_SPL_LO;
					end
				end else begin
					res_status_d = ST_NOFIT;
					res_grant_d  = 1'b0;
					state_d      = S_RES;
				end
			end
			S_DN: begin
				op = OP_DN;
				if (!stat.dn_more) begin
					state_d = S_SPL_HI;
				end
			end
			S_SPL_HI: begin
				op      = OP_SPLIT_HI;
				state_d = S_SPL_LO;
			end
			S_SPL_LO: begin
				op           = OP_SPLIT_LO;
				res_status_d = ST_OK;
				res_grant_d  = 1'b1;
				state_d      = S_RES;
			end
			S_MERGE: begin
				op      = OP_MERGE;
				state_d = stat.up_any ? S_UP : S_FIN;
			end
			S_UP: begin
				op = OP_UP;
				if (!stat.up_more) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				op           = OP_SHRINK;
				res_status_d = ST_OK;
				res_grant_d  = 1'b0;
				state_d      = S_RES;
			end
			S_RES: begin
				if (!stat.out_busy) begin
					op      = OP_RES;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	// pending result code
	always_ff @(posedge clk) begin
		res_status_q <= res_status_d;
		res_grant_q  <= res_grant_d;
	end

	assign cmd.op     = op;
	assign cmd.status = res_status_q;
	assign cmd.grant  = res_grant_q;

endmodule

@@ rtl/first_fit_pool_allocator.sv @@
// ----------------------------------------------------------------------------
// first_fit_pool_allocator: first-fit pool allocator with split and coalesce
//
//   channel  dir  handshake     payload
//   req      in   valid/ready   command, request_size, payload_offset
//   rsp      out  valid/ready   status, granted_offset
//
// The scan reads one table entry per cycle; a hit goes on to the decide state and
// a miss on the last entry straight to the result state. A split or merge then
// moves one table entry per cycle, and scan plus shift never pass the block
// count. The result state waits while the output register holds an untaken
// result; the controller then returns to idle before the next item is taken.
// After reset the init state writes table entry 0 before the first item.
// req is taken only while no item is in work; a result held in the output
// register does not block the next item, but the one after it waits for rsp.
// ----------------------------------------------------------------------------
module first_fit_pool_allocator import fpa_pkg::*; #(
	parameter int POOL_BYTES   = 1024,
	parameter int HEADER_BYTES = 24,
	parameter int MAX_BLOCKS   = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	fpa_req_if.sink   req,
	fpa_rsp_if.source rsp
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// controller
	fpa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// datapath
	fpa_dp #(
		.POOL_BYTES   (POOL_BYTES),
		.HEADER_BYTES (HEADER_BYTES),
		.MAX_BLOCKS   (MAX_BLOCKS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.command        (req.command),
		.request_size   (req.request_size),
		.payload_offset (req.payload_offset),
		.res_valid      (rsp.valid),
		.res_ready      (rsp.ready),
		.status         (rsp.status),
		.granted_offset (rsp.granted_offset)
	);

endmodule

@@ dv/tb_first_fit_pool_allocator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_first_fit_pool_allocator: self-checking bench for the pool allocator
// A shadow block table predicts every status and granted offset. Directed
// items cover the edge cases, then about 700 random items follow, mostly
// allocates and frees of live blocks. Idling on both channels varies by phase.
// ----------------------------------------------------------------------------
module tb_first_fit_pool_allocator;
	import fpa_pkg::*;

	localparam int POOL_BYTES     = 1024;
	localparam int HEADER_BYTES   = 24;
	localparam int MAX_BLOCKS     = 64;
	localparam int CLK_PERIOD     = 4;
	localparam int RESET_CYCLES   = 6;
	localparam int RANDOM_ITEMS   = 700;
	// limit lies far above the longest item, receiver stalls included
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 2 * MAX_BLOCKS + 64;

	typedef struct packed {
		logic [CMD_W-1:0]    command;
		logic [SIZE_W-1:0]   request_size;
		logic [OFF_W-1:0]    payload_offset;
		logic [STATUS_W-1:0] status;
		logic [OFF_W-1:0]    granted_offset;
	} pool_job_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [OFF_W-1:0]    granted_offset;
	} pool_result_t;

	logic clk = 1'b0;
	logic arst_n;

	fpa_req_if req_ch ();
	fpa_rsp_if rsp_ch ();

	first_fit_pool_allocator #(
		.POOL_BYTES   (POOL_BYTES),
		.HEADER_BYTES (HEADER_BYTES),
		.MAX_BLOCKS   (MAX_BLOCKS)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch.sink),
		.rsp    (rsp_ch.source)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// shadow block table
	int blk_size [MAX_BLOCKS];
	bit blk_free [MAX_BLOCKS];
	int blk_count;

	pool_job_t    pending_jobs [$];
	pool_result_t grant_queue  [$];
	pool_result_t held_result;
	pool_result_t got_result;
	pool_result_t want_result;
	int           total_items;
	int           items_taken;
	int           mismatches;
	int           quiet_cycles;

	task automatic report_mismatch(input string what);
		$display("[%0t] mismatch: %s", $realtime, what);
		mismatches++;
	endtask

	function automatic void table_reset();
		for (int i = 0; i < MAX_BLOCKS; i++) begin
			blk_size[i] = 0;
			blk_free[i] = 1'b0;
		end
		blk_size[0] = POOL_BYTES - HEADER_BYTES;
		blk_free[0] = 1'b1;
		blk_count   = 1;
	endfunction

	// close the gap left by entry k
	function automatic void table_remove(input int k);
		for (int j = k; j + 1 < blk_count; j++) begin
			blk_size[j] = blk_size[j + 1];
			blk_free[j] = blk_free[j + 1];
		end
		blk_count--;
		blk_size[blk_count] = 0;
		blk_free[blk_count] = 1'b0;
	endfunction

	// first fit, split or exact fit on allocate; release and coalesce on free
	function automatic pool_result_t predict_pool(input pool_job_t job);
		pool_result_t res;
		int addr;
		int i;
		int sz;
		int want;
		int off;
		res.status         = ST_NOFIT;
		res.granted_offset = '0;
		addr = 0;
		i    = 0;
		want = job.request_size;
		off  = job.payload_offset;
		if (job.command == CMD_ALLOC) begin
			while (i < blk_count && !(blk_free[i] && blk_size[i] >= want)) begin
				addr += HEADER_BYTES + blk_size[i];
				i++;
			end
			if (i < blk_count) begin
				sz = blk_size[i];
				if (sz == want) begin
					blk_free[i]        = 1'b0;
					res.status         = ST_OK;
					res.granted_offset = OFF_W'(addr + HEADER_BYTES);
				end else if (sz > want + HEADER_BYTES && blk_count < MAX_BLOCKS) begin
					for (int k = blk_count; k > i + 1; k--) begin
						blk_size[k] = blk_size[k - 1];
						blk_free[k] = blk_free[k - 1];
					end
					blk_size[i + 1] = sz - want - HEADER_BYTES;
					blk_free[i + 1] = 1'b1;
					blk_size[i]     = want;
					blk_free[i]     = 1'b0;
					blk_count++;
					res.status         = ST_OK;
					res.granted_offset = OFF_W'(addr + HEADER_BYTES);
				end
			end
		end else begin
			res.status = ST_BADOFF;
			while (i < blk_count && addr + HEADER_BYTES != off) begin
				addr += HEADER_BYTES + blk_size[i];
				i++;
			end
			if (i < blk_count && !blk_free[i]) begin
				blk_free[i] = 1'b1;
				if (i + 1 < blk_count && blk_free[i + 1]) begin
					blk_size[i] += HEADER_BYTES + blk_size[i + 1];
					table_remove(i + 1);
				end
				if (i > 0 && blk_free[i - 1]) begin
					blk_size[i - 1] += HEADER_BYTES + blk_size[i];
					table_remove(i);
				end
				res.status = ST_OK;
			end
		end
		return res;
	endfunction

	// random entry with the given free mark, -1 when there is none
	function automatic int pick_block(input bit want_free);
		int hits;
		int nth;
		hits = 0;
		for (int i = 0; i < blk_count; i++)
			if (blk_free[i] == want_free)
				hits++;
		if (hits == 0)
			return -1;
		nth = $urandom_range(hits - 1);
		for (int i = 0; i < blk_count; i++) begin
			if (blk_free[i] == want_free) begin
				if (nth == 0)
					return i;
				nth--;
			end
		end
		return -1;
	endfunction

	function automatic int payload_of(input int idx);
		int addr;
		addr = 0;
		for (int i = 0; i < idx; i++)
			addr += HEADER_BYTES + blk_size[i];
		return addr + HEADER_BYTES;
	endfunction

	// predict the item's result and queue it for the driver
	task automatic queue_item(input logic cmd, input int size, input int off);
		pool_job_t    job;
		pool_result_t res;
		job.command        = cmd;
		job.request_size   = SIZE_W'(size);
		job.payload_offset = OFF_W'(off);
		job.status         = '0;
		job.granted_offset = '0;
		res = predict_pool(job);
		job.status         = res.status;
		job.granted_offset = res.granted_offset;
		pending_jobs.push_back(job);
	endtask

	// 0 no idling, 1 sender idles, 2 receiver stalls, 3 both lightly
	function automatic int idle_phase();
		if (total_items == 0)
			return 0;
		return (items_taken * 4) / total_items;
	endfunction

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid          <= 1'b0;
			req_ch.command        <= CMD_ALLOC;
			req_ch.request_size   <= '0;
			req_ch.payload_offset <= '0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				grant_queue.push_back(held_result);
				items_taken++;
			end
			if (!req_ch.valid || req_ch.ready) begin
				if (pending_jobs.size() > 0 &&
						$urandom_range(99) >= ((idle_phase() == 1) ? 59 :
						(idle_phase() == 3) ? 17 : 0)) begin
					held_result.status         = pending_jobs[0].status;
					held_result.granted_offset = pending_jobs[0].granted_offset;
					req_ch.valid          <= 1'b1;
					req_ch.command        <= pending_jobs[0].command;
					req_ch.request_size   <= pending_jobs[0].request_size;
					req_ch.payload_offset <= pending_jobs[0].payload_offset;
					void'(pending_jobs.pop_front());
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor and receiver stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				got_result.status         = rsp_ch.status;
				got_result.granted_offset = rsp_ch.granted_offset;
				if (grant_queue.size() == 0) begin
					report_mismatch($sformatf("result status %0d offset %0d with none due",
						got_result.status, got_result.granted_offset));
				end else begin
					want_result = grant_queue.pop_front();
					if (got_result.status !== want_result.status)
						report_mismatch($sformatf("status %0d, wanted %0d",
							got_result.status, want_result.status));
					if (got_result.granted_offset !== want_result.granted_offset)
						report_mismatch($sformatf("granted_offset %0d, wanted %0d",
							got_result.granted_offset, want_result.granted_offset));
				end
			end
			rsp_ch.ready <= ($urandom_range(99) >= ((idle_phase() == 2) ? 59 :
				(idle_phase() == 3) ? 17 : 0));
		end
	end

	// watchdog on cycles with no item moving on either channel
	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : stimulus
		int size;
		int off;
		int idx;
		int roll;
		int pick;
		logic cmd;

		req_ch.valid          = 1'b0;
		req_ch.command        = CMD_ALLOC;
		req_ch.request_size   = '0;
		req_ch.payload_offset = '0;
		rsp_ch.ready          = 1'b0;
		arst_n                = 1'b0;
		items_taken           = 0;
		mismatches            = 0;
		quiet_cycles          = 0;
		total_items           = 0;
		table_reset();

		// directed: pool extremes, split limits, no further search, merges
		queue_item(CMD_ALLOC, 1023, 1023);      // larger than the pool
		queue_item(CMD_ALLOC, 976, 0);          // remainder would equal a header
		queue_item(CMD_ALLOC, 1000, 1023);      // exact fit of the whole pool
		queue_item(CMD_ALLOC, 0, 0);            // nothing free
		queue_item(CMD_FREE, 1023, 24);
		queue_item(CMD_FREE, 0, 24);            // already free
		queue_item(CMD_FREE, 1023, 0);          // not a payload start
		queue_item(CMD_FREE, 0, 1023);
		queue_item(CMD_ALLOC, 0, 1023);         // zero-byte block
		queue_item(CMD_ALLOC, 100, 0);
		queue_item(CMD_ALLOC, 200, 0);
		queue_item(CMD_FREE, 1023, 48);         // both neighbours in use
		queue_item(CMD_ALLOC, 90, 0);           // first free too small to split
		queue_item(CMD_ALLOC, 100, 0);          // exact refit
		queue_item(CMD_FREE, 0, 396);           // free remainder block
		queue_item(CMD_FREE, 0, 48);
		queue_item(CMD_FREE, 1023, 172);        // merges with both neighbours
		queue_item(CMD_FREE, 0, 24);            // merges with next only
		queue_item(CMD_ALLOC, 975, 0);          // one-byte remainder at offset 1023
		queue_item(CMD_FREE, 0, 1023);          // last block is free
		queue_item(CMD_ALLOC, 1, 0);            // last block taken exactly
		queue_item(CMD_FREE, 1023, 1023);
		queue_item(CMD_FREE, 0, 24);

		// random: mostly live frees and small allocates, some noise
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			size = $urandom_range(1023);
			off  = $urandom_range(1023);
			cmd  = CMD_ALLOC;
			roll = $urandom_range(99);
			pick = $urandom_range(99);
			if (roll < 55) begin
				if (pick < 40) begin
					size = $urandom_range(40);
				end else if (pick < 70) begin
					size = $urandom_range(200);
				end else if (pick < 85) begin
					idx = pick_block(1'b1);
					if (idx >= 0)
						size = blk_size[idx];
				end
			end else begin
				cmd = CMD_FREE;
				if (pick < 75)
					idx = pick_block(1'b0);
				else if (pick < 87)
					idx = pick_block(1'b1);
				else
					idx = -1;
				if (idx >= 0)
					off = payload_of(idx);
			end
			queue_item(cmd, size, off);
		end
		total_items = pending_jobs.size();

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		while (items_taken < total_items || grant_queue.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0 && grant_queue.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
